>>> src/dbdg_pkg.sv
// Shared types and constants for the dual beacon debounce guidance block.
// Used by dbdg_core, the top level and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbdg_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int NOW_W    = 32;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 16;

	// Position codes
	localparam logic [1:0] CLASS_LOST   = 2'd0;
	localparam logic [1:0] CLASS_LEFT   = 2'd1;
	localparam logic [1:0] CLASS_RIGHT  = 2'd2;
	localparam logic [1:0] CLASS_CENTER = 2'd3;
	localparam logic [2:0] HINT_PAUSE   = 3'd4;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_THR    = 2'd2;

	localparam logic [15:0] LOST_TIMEOUT_RST    = 16'd3000;
	localparam logic [7:0]  SAMPLE_INTERVAL_RST = 8'd16;
	localparam logic [7:0]  DEBOUNCE_THR_RST    = 8'd3;

	typedef struct packed {
		logic [15:0] lost_timeout_ms;
		logic [7:0]  sample_interval_ms;
		logic [7:0]  debounce_threshold;
	} cfg_t;

	typedef struct packed {
		logic       right_steady;
		logic       left_steady;
		logic       any_receiver;
		logic       paused;
		logic [1:0] position;
		logic [2:0] guidance_hint;
	} result_t;

	function automatic logic [7:0] bump(input logic [7:0] count, input logic seen);
		logic [7:0] r;
		if (!seen) begin
			r = 8'd0;
		end else if (count == COUNT_MAX) begin
			r = COUNT_MAX;
		end else begin
			r = count + 8'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/dbdg_core.sv
// Next-state and result logic for one tick of the guidance block.
// Purely combinational; depends on dbdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbdg_core #(
	parameter int TIME_BITS = dbdg_pkg::TIME_BITS_DEF
) (
	input  wire dbdg_pkg::cfg_t        cfg,
	input  wire [dbdg_pkg::NOW_W-1:0]  now_ms,
	input  wire                        docked,
	input  wire                        left_seen,
	input  wire                        right_seen,
	input  wire [1:0]                  class_cur,
	input  wire [7:0]                  lcnt_cur,
	input  wire [7:0]                  rcnt_cur,
	input  wire [TIME_BITS-1:0]        last_cur,
	input  wire [TIME_BITS-1:0]        loss_cur,
	input  wire                        pause_cur,
	input  wire                        anchored_cur,
	output logic [1:0]                 class_nxt,
	output logic [7:0]                 lcnt_nxt,
	output logic [7:0]                 rcnt_nxt,
	output logic [TIME_BITS-1:0]       last_nxt,
	output logic [TIME_BITS-1:0]       loss_nxt,
	output logic                       pause_nxt,
	output logic                       anchored_nxt,
	output dbdg_pkg::result_t          result
);

	logic [63:0]          now_ext;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] gap;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] interval_ext;
	logic [TIME_BITS-1:0] timeout_ext;
	logic [7:0]           lcnt_smp;
	logic [7:0]           rcnt_smp;
	logic [1:0]           class_smp;
	logic [TIME_BITS-1:0] anchor_smp;
	logic                 sample;
	logic                 lsteady;
	logic                 rsteady;

	assign now_ext      = {32'd0, now_ms};
	assign now_t        = now_ext[TIME_BITS-1:0];
	assign interval_ext = {{(TIME_BITS-8){1'b0}}, cfg.sample_interval_ms};
	assign timeout_ext  = {{(TIME_BITS-16){1'b0}}, cfg.lost_timeout_ms};

	assign gap    = now_t - last_cur;
	// a negative gap (top bit set) never samples
	assign sample = !docked && !gap[TIME_BITS-1] && (gap >= interval_ext);

	assign lcnt_smp   = dbdg_pkg::bump(lcnt_cur, left_seen);
	assign rcnt_smp   = dbdg_pkg::bump(rcnt_cur, right_seen);
	assign class_smp  = {rcnt_smp > cfg.debounce_threshold,
		lcnt_smp > cfg.debounce_threshold};
	assign anchor_smp = anchored_cur ? loss_cur : now_t;
	assign elapsed    = now_t - anchor_smp;

	always_comb begin
		class_nxt    = class_cur;
		lcnt_nxt     = lcnt_cur;
		rcnt_nxt     = rcnt_cur;
		last_nxt     = last_cur;
		loss_nxt     = loss_cur;
		pause_nxt    = pause_cur;
		anchored_nxt = anchored_cur;
		if (docked) begin
			class_nxt    = dbdg_pkg::CLASS_CENTER;
			pause_nxt    = 1'b0;
			anchored_nxt = 1'b0;
			lcnt_nxt     = 8'd0;
			rcnt_nxt     = 8'd0;
		end else if (sample) begin
			last_nxt  = now_t;
			lcnt_nxt  = lcnt_smp;
			rcnt_nxt  = rcnt_smp;
			class_nxt = class_smp;
			if (class_smp == dbdg_pkg::CLASS_LOST) begin
				loss_nxt     = anchor_smp;
				anchored_nxt = 1'b1;
				pause_nxt    = pause_cur || (elapsed >= timeout_ext);
			end else begin
				anchored_nxt = 1'b0;
				pause_nxt    = 1'b0;
			end
		end
	end

	// steady flags always follow the held counts and the current threshold
	assign lsteady = lcnt_nxt > cfg.debounce_threshold;
	assign rsteady = rcnt_nxt > cfg.debounce_threshold;

	always_comb begin
		result.guidance_hint = pause_nxt ? dbdg_pkg::HINT_PAUSE : {1'b0, class_nxt};
		result.position      = class_nxt;
		result.paused        = pause_nxt;
		result.any_receiver  = (class_nxt != dbdg_pkg::CLASS_LOST);
		result.left_steady   = lsteady;
		result.right_steady  = rsteady;
	end

endmodule

`default_nettype wire

>>> src/dual_beacon_debounce_guidance.sv
// Top level of the dual beacon debounce guidance block: stream ports,
// configuration registers, state and the result register. Uses dbdg_pkg, dbdg_core.
// Takes one tick beat per clock unless the output stalls. A beat is captured in an
// input register, its state update is done in one pass of dbdg_core, and the result
// lands in the output register; one item per cycle is sustained while the output
// drains. A stalled output holds the pipe; the input side keeps taking beats as long
// as the input register drains.
`timescale 1ns / 1ps
`default_nettype none

module dual_beacon_debounce_guidance #(
	parameter int TIME_BITS = dbdg_pkg::TIME_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// [31:0] now_ms, [32] docked, [33] left_seen, [34] right_seen, rest zero
	input  wire [dbdg_pkg::IN_W-1:0]        s_tdata,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// [2:0] guidance_hint, [4:3] position, [5] paused, [6] any_receiver,
	// [7] left_steady, [8] right_steady, rest zero
	output logic [dbdg_pkg::OUT_W-1:0]      m_tdata,
	input  wire                             cfg_wen,
	input  wire [dbdg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [dbdg_pkg::CFG_W-1:0]       cfg_data
);

	dbdg_pkg::cfg_t    cfg_q;
	logic              valid_s1;
	logic [dbdg_pkg::NOW_W-1:0] now_s1;
	logic              docked_s1;
	logic              lseen_s1;
	logic              rseen_s1;
	logic              advance;

	logic [1:0]           class_q, class_nxt;
	logic [7:0]           lcnt_q, lcnt_nxt;
	logic [7:0]           rcnt_q, rcnt_nxt;
	logic [TIME_BITS-1:0] last_q, last_nxt;
	logic [TIME_BITS-1:0] loss_q, loss_nxt;
	logic                 pause_q, pause_nxt;
	logic                 anchored_q, anchored_nxt;
	dbdg_pkg::result_t    result;
	dbdg_pkg::result_t    result_q;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lost_timeout_ms    <= dbdg_pkg::LOST_TIMEOUT_RST;
			cfg_q.sample_interval_ms <= dbdg_pkg::SAMPLE_INTERVAL_RST;
			cfg_q.debounce_threshold <= dbdg_pkg::DEBOUNCE_THR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				dbdg_pkg::REG_LOST_TIMEOUT: cfg_q.lost_timeout_ms <= cfg_data;
				dbdg_pkg::REG_SAMPLE_INTERVAL: cfg_q.sample_interval_ms <= cfg_data[7:0];
				dbdg_pkg::REG_DEBOUNCE_THR: cfg_q.debounce_threshold <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// move the input register into the result register when it is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1    <= s_tdata[31:0];
			docked_s1 <= s_tdata[32];
			lseen_s1  <= s_tdata[33];
			rseen_s1  <= s_tdata[34];
		end
	end

	dbdg_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.cfg          (cfg_q),
		.now_ms       (now_s1),
		.docked       (docked_s1),
		.left_seen    (lseen_s1),
		.right_seen   (rseen_s1),
		.class_cur    (class_q),
		.lcnt_cur     (lcnt_q),
		.rcnt_cur     (rcnt_q),
		.last_cur     (last_q),
		.loss_cur     (loss_q),
		.pause_cur    (pause_q),
		.anchored_cur (anchored_q),
		.class_nxt    (class_nxt),
		.lcnt_nxt     (lcnt_nxt),
		.rcnt_nxt     (rcnt_nxt),
		.last_nxt     (last_nxt),
		.loss_nxt     (loss_nxt),
		.pause_nxt    (pause_nxt),
		.anchored_nxt (anchored_nxt),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q    <= dbdg_pkg::CLASS_LOST;
			lcnt_q     <= 8'd0;
			rcnt_q     <= 8'd0;
			last_q     <= '0;
			loss_q     <= '0;
			pause_q    <= 1'b0;
			anchored_q <= 1'b0;
		end else if (advance) begin
			class_q    <= class_nxt;
			lcnt_q     <= lcnt_nxt;
			rcnt_q     <= rcnt_nxt;
			last_q     <= last_nxt;
			loss_q     <= loss_nxt;
			pause_q    <= pause_nxt;
			anchored_q <= anchored_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(dbdg_pkg::OUT_W - $bits(dbdg_pkg::result_t)){1'b0}}, result_q};

endmodule

`default_nettype wire

>>> src/dbdg_checker.sv
// Port-level checker for dual_beacon_debounce_guidance, bound to the top level.
// Uses dbdg_pkg for the position and hint codes.
`timescale 1ns / 1ps
`default_nettype none

module dbdg_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [dbdg_pkg::OUT_W-1:0]     m_tdata
);

	logic [2:0] hint;
	logic [1:0] pos;
	logic       paused;
	logic       any_rx;

	assign hint   = m_tdata[2:0];
	assign pos    = m_tdata[4:3];
	assign paused = m_tdata[5];
	assign any_rx = m_tdata[6];

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_hint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (paused ? (hint == dbdg_pkg::HINT_PAUSE) : (hint == {1'b0, pos})))
		else $error("guidance hint disagrees with pause and position");

	a_any: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (any_rx == (pos != dbdg_pkg::CLASS_LOST)))
		else $error("any_receiver disagrees with position");

	// pause is only ever set while lost and cleared on any other class
	a_pause_lost: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && paused |-> pos == dbdg_pkg::CLASS_LOST)
		else $error("paused while a beacon position is held");

endmodule

bind dual_beacon_debounce_guidance dbdg_checker u_dbdg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
